// ===== src/dtrh_pkg.sv =====
// Shared types, codes and defaults of the device table with signal-strength history.
package dtrh_pkg;

    localparam int TABLE_ENTRIES_DEF = 32;
    localparam int HISTORY_DEPTH_DEF = 16;
    localparam int TRACK_LIMIT_DEF   = 8;
    localparam int ADDR_W            = 48;

    localparam logic [1:0] OP_OBSERVE   = 2'd0;
    localparam logic [1:0] OP_TRACK_ON  = 2'd1;
    localparam logic [1:0] OP_TRACK_OFF = 2'd2;
    localparam logic [1:0] OP_HIST_READ = 2'd3;

    localparam logic [2:0] KIND_REPORT     = 3'd0;
    localparam logic [2:0] KIND_TRACK_ON   = 3'd1;
    localparam logic [2:0] KIND_TRACK_OFF  = 3'd2;
    localparam logic [2:0] KIND_HIST_START = 3'd3;
    localparam logic [2:0] KIND_SAMPLE     = 3'd4;
    localparam logic [2:0] KIND_HIST_DONE  = 3'd5;
    localparam logic [2:0] KIND_ERROR      = 3'd6;

    localparam logic [1:0] ERR_NONE        = 2'd0;
    localparam logic [1:0] ERR_TABLE_FULL  = 2'd1;
    localparam logic [1:0] ERR_TRACK_LIMIT = 2'd2;
    localparam logic [1:0] ERR_NOT_FOUND   = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC,
        ST_HIST
    } back_state_t;

    typedef struct packed {
        logic [1:0]        op;
        logic              may_alloc;
        logic [ADDR_W-1:0] addr;
        logic signed [7:0] rssi;
        logic [31:0]       now;
    } cmd_t;

    typedef struct packed {
        logic              valid;
        logic [2:0]        kind;
        logic [1:0]        err;
        logic [ADDR_W-1:0] addr;
        logic signed [7:0] rssi;
        logic              tracked;
        logic [31:0]       seen;
        logic              last;
    } result_t;

endpackage

// ===== src/dtrh_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module dtrh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                    wdata,
    input  logic                                re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                    rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/dtrh_front.sv =====
// Front end: takes commands, classifies them and queues them for the back end.
module dtrh_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [1:0]     opcode,
    input  logic [47:0]    device_address,
    input  logic signed [7:0] signal_strength,
    input  logic [31:0]    now_ms,
    output logic           busy,
    output dtrh_pkg::cmd_t q_head,
    output logic           q_valid,
    input  logic           q_pop
);
    import dtrh_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;
    cmd_t       cmd_in;

    // Observations and track starts may claim a free slot; the others only look up.
    always_comb
    begin
        cmd_in.op        = opcode;
        cmd_in.may_alloc = (opcode == OP_OBSERVE) || (opcode == OP_TRACK_ON);
        cmd_in.addr      = device_address;
        cmd_in.rssi      = signal_strength;
        cmd_in.now       = now_ms;
    end

    assign busy    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_head  = entry_reg[rd_ptr_reg];
    assign push    = start && !busy;
    assign pop     = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = 2'(count_reg + {1'b0, push} - {1'b0, pop});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg != 2'd3)
        else $error("command queue count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_valid && !push) |=> (count_reg == $past(count_reg) - 2'd1))
        else $error("command queue lost a pop");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> q_valid)
        else $error("command queue empty after a push");

endmodule

// ===== src/dtrh_back.sv =====
// Back end: slot search, table update and result sequencing.
module dtrh_back #(
    parameter int TABLE_ENTRIES = dtrh_pkg::TABLE_ENTRIES_DEF,
    parameter int HISTORY_DEPTH = dtrh_pkg::HISTORY_DEPTH_DEF,
    parameter int TRACK_LIMIT   = dtrh_pkg::TRACK_LIMIT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dtrh_pkg::cmd_t    q_head,
    input  logic              q_valid,
    output logic              q_pop,
    output dtrh_pkg::result_t res
);
    import dtrh_pkg::*;

    localparam int IW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW  = $clog2(TABLE_ENTRIES + 1);
    localparam int PW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FW  = $clog2(HISTORY_DEPTH + 1);
    localparam int TW  = (TRACK_LIMIT > 0) ? $clog2(TRACK_LIMIT + 1) : 1;
    localparam int HD  = TABLE_ENTRIES * HISTORY_DEPTH;
    localparam int HAW = (HD > 1) ? $clog2(HD) : 1;
    localparam int SW  = $clog2(2 * HISTORY_DEPTH + 1);

    back_state_t state_reg, state_next;

    logic [CW-1:0]  scan_cnt_reg, scan_cnt_next;
    logic           cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]  cmp_idx_reg, cmp_idx_next;
    logic           hit_reg, hit_next;
    logic [IW-1:0]  hit_idx_reg, hit_idx_next;
    logic           free_found_reg, free_found_next;
    logic [IW-1:0]  free_idx_reg, free_idx_next;
    logic [TW-1:0]  trk_total_reg, trk_total_next;
    logic [PW-1:0]  hidx_reg, hidx_next;
    logic [FW-1:0]  n_reg, n_next;
    logic [FW-1:0]  fill_cur_reg, fill_cur_next;
    logic           hrd_vld_reg, hrd_vld_next;
    result_t        res_reg, res_next;

    logic [TABLE_ENTRIES-1:0] used_reg;
    logic [TABLE_ENTRIES-1:0] trk_reg;
    logic [PW-1:0]            pos_reg  [TABLE_ENTRIES];
    logic [FW-1:0]            fill_reg [TABLE_ENTRIES];

    logic [ADDR_W-1:0] addr_rdata;
    logic [7:0]        hist_rdata;
    logic              scan_issue;
    logic              scan_match;
    logic              scan_done;
    logic              hist_issue;
    logic              hist_done;
    logic [IW-1:0]     slot_sel;
    logic              slot_ok;
    logic              alloc_en;
    logic              trk_we;
    logic              trk_new;
    logic              pf_we;
    logic [PW-1:0]     pos_new;
    logic [FW-1:0]     fill_new;
    logic [PW-1:0]     pos_eff;
    logic [FW-1:0]     fill_eff;
    logic              trk_eff;
    logic              hist_we;
    logic [HAW-1:0]    hist_waddr;
    logic [HAW-1:0]    hist_raddr;
    logic [SW-1:0]     start_sum;
    logic [PW-1:0]     start_idx;

    assign scan_issue = (state_reg == ST_SCAN) && (scan_cnt_reg != CW'(TABLE_ENTRIES));
    assign scan_match = used_reg[cmp_idx_reg] && (addr_rdata == q_head.addr);
    assign scan_done  = cmp_vld_reg && (scan_match || (cmp_idx_reg == IW'(TABLE_ENTRIES - 1)));
    assign hist_issue = (state_reg == ST_HIST) && (n_reg != fill_cur_reg);
    assign hist_done  = (state_reg == ST_HIST) && (n_reg == fill_cur_reg) && !hrd_vld_reg;

    assign slot_sel = hit_reg ? hit_idx_reg : free_idx_reg;
    assign slot_ok  = hit_reg || free_found_reg;
    assign pos_eff  = hit_reg ? pos_reg[slot_sel] : '0;
    assign fill_eff = hit_reg ? fill_reg[slot_sel] : '0;
    assign trk_eff  = hit_reg ? trk_reg[slot_sel] : 1'b0;

    assign hist_waddr = HAW'(HAW'(slot_sel) * HAW'(HISTORY_DEPTH) + HAW'(pos_eff));
    assign hist_raddr = HAW'(HAW'(hit_idx_reg) * HAW'(HISTORY_DEPTH) + HAW'(hidx_reg));

    // Oldest sample sits fill places behind the write position, modulo the depth.
    assign start_sum = SW'(SW'(pos_reg[hit_idx_reg]) + SW'(HISTORY_DEPTH)
                           - SW'(fill_reg[hit_idx_reg]));
    assign start_idx = (start_sum >= SW'(HISTORY_DEPTH))
                       ? PW'(start_sum - SW'(HISTORY_DEPTH)) : PW'(start_sum);

    dtrh_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_addr_ram (
        .clk   (clk),
        .we    (alloc_en),
        .waddr (slot_sel),
        .wdata (q_head.addr),
        .re    (scan_issue),
        .raddr (scan_cnt_reg[IW-1:0]),
        .rdata (addr_rdata)
    );

    dtrh_ram #(
        .WIDTH (8),
        .DEPTH (HD)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (q_head.rssi),
        .re    (hist_issue),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if ((q_head.op == OP_HIST_READ) && hit_reg)
                begin
                    state_next = ST_HIST;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_HIST:
            begin
                if (hist_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        scan_cnt_next   = scan_cnt_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        trk_total_next  = trk_total_reg;
        hidx_next       = hidx_reg;
        n_next          = n_reg;
        fill_cur_next   = fill_cur_reg;
        hrd_vld_next    = 1'b0;
        q_pop           = 1'b0;
        alloc_en        = 1'b0;
        trk_we          = 1'b0;
        trk_new         = 1'b0;
        pf_we           = 1'b0;
        pos_new         = '0;
        fill_new        = '0;
        hist_we         = 1'b0;

        res_next         = '0;
        res_next.kind    = KIND_REPORT;
        res_next.err     = ERR_NONE;
        res_next.addr    = q_head.addr;
        res_next.last    = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                scan_cnt_next   = '0;
                hit_next        = 1'b0;
                free_found_next = 1'b0;
            end
            ST_SCAN:
            begin
                if (scan_issue && !scan_done)
                begin
                    cmp_vld_next  = 1'b1;
                    cmp_idx_next  = scan_cnt_reg[IW-1:0];
                    scan_cnt_next = CW'(scan_cnt_reg + 1'b1);
                end
                if (cmp_vld_reg)
                begin
                    if (scan_match)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = cmp_idx_reg;
                    end
                    if (!used_reg[cmp_idx_reg] && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = cmp_idx_reg;
                    end
                end
            end
            ST_EXEC:
            begin
                res_next.valid = 1'b1;
                q_pop          = 1'b1;
                if (q_head.may_alloc && !slot_ok)
                begin
                    res_next.kind = KIND_ERROR;
                    res_next.err  = ERR_TABLE_FULL;
                end
                else
                begin
                    // A new slot starts untracked with an empty history.
                    if (q_head.may_alloc && !hit_reg)
                    begin
                        alloc_en = 1'b1;
                        trk_we   = 1'b1;
                        trk_new  = 1'b0;
                        pf_we    = 1'b1;
                    end
                    unique case (q_head.op)
                        OP_OBSERVE:
                        begin
                            hist_we  = 1'b1;
                            pf_we    = 1'b1;
                            pos_new  = (pos_eff == PW'(HISTORY_DEPTH - 1))
                                       ? '0 : PW'(pos_eff + 1'b1);
                            fill_new = (fill_eff == FW'(HISTORY_DEPTH))
                                       ? fill_eff : FW'(fill_eff + 1'b1);
                            res_next.rssi    = q_head.rssi;
                            res_next.tracked = trk_eff;
                            res_next.seen    = q_head.now;
                        end
                        OP_TRACK_ON:
                        begin
                            if (!trk_eff && (32'(trk_total_reg) >= 32'(TRACK_LIMIT)))
                            begin
                                res_next.kind = KIND_ERROR;
                                res_next.err  = ERR_TRACK_LIMIT;
                            end
                            else
                            begin
                                if (!trk_eff)
                                begin
                                    trk_total_next = TW'(trk_total_reg + 1'b1);
                                    trk_we         = 1'b1;
                                    trk_new        = 1'b1;
                                end
                                res_next.kind    = KIND_TRACK_ON;
                                res_next.tracked = 1'b1;
                            end
                        end
                        OP_TRACK_OFF:
                        begin
                            if (hit_reg && trk_reg[hit_idx_reg])
                            begin
                                trk_we  = 1'b1;
                                trk_new = 1'b0;
                                if (trk_total_reg != '0)
                                begin
                                    trk_total_next = TW'(trk_total_reg - 1'b1);
                                end
                            end
                            res_next.kind = KIND_TRACK_OFF;
                        end
                        OP_HIST_READ:
                        begin
                            if (!hit_reg)
                            begin
                                res_next.kind = KIND_ERROR;
                                res_next.err  = ERR_NOT_FOUND;
                            end
                            else
                            begin
                                q_pop         = 1'b0;
                                res_next.kind = KIND_HIST_START;
                                res_next.last = 1'b0;
                                hidx_next     = start_idx;
                                n_next        = '0;
                                fill_cur_next = fill_reg[hit_idx_reg];
                            end
                        end
                        default:
                        begin
                            res_next.kind = KIND_ERROR;
                        end
                    endcase
                end
            end
            ST_HIST:
            begin
                if (hist_issue)
                begin
                    hrd_vld_next = 1'b1;
                    n_next       = FW'(n_reg + 1'b1);
                    hidx_next    = (hidx_reg == PW'(HISTORY_DEPTH - 1))
                                   ? '0 : PW'(hidx_reg + 1'b1);
                end
                if (hrd_vld_reg)
                begin
                    res_next.valid = 1'b1;
                    res_next.kind  = KIND_SAMPLE;
                    res_next.rssi  = hist_rdata;
                    res_next.last  = 1'b0;
                end
                else if (hist_done)
                begin
                    res_next.valid = 1'b1;
                    res_next.kind  = KIND_HIST_DONE;
                    q_pop          = 1'b1;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            scan_cnt_reg   <= '0;
            cmp_vld_reg    <= 1'b0;
            cmp_idx_reg    <= '0;
            hit_reg        <= 1'b0;
            hit_idx_reg    <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            trk_total_reg  <= '0;
            hidx_reg       <= '0;
            n_reg          <= '0;
            fill_cur_reg   <= '0;
            hrd_vld_reg    <= 1'b0;
            res_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_cnt_reg   <= scan_cnt_next;
            cmp_vld_reg    <= cmp_vld_next;
            cmp_idx_reg    <= cmp_idx_next;
            hit_reg        <= hit_next;
            hit_idx_reg    <= hit_idx_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            trk_total_reg  <= trk_total_next;
            hidx_reg       <= hidx_next;
            n_reg          <= n_next;
            fill_cur_reg   <= fill_cur_next;
            hrd_vld_reg    <= hrd_vld_next;
            res_reg        <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            trk_reg  <= '0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                pos_reg[i]  <= '0;
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                if (slot_sel == IW'(i))
                begin
                    if (alloc_en)
                    begin
                        used_reg[i] <= 1'b1;
                    end
                    if (trk_we)
                    begin
                        trk_reg[i] <= trk_new;
                    end
                    if (pf_we)
                    begin
                        pos_reg[i]  <= pos_new;
                        fill_reg[i] <= fill_new;
                    end
                end
            end
        end
    end

    assign res = res_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(trk_reg) == int'(trk_total_reg))
        else $error("tracked count disagrees with tracked marks");

    assert property (@(posedge clk) disable iff (!rst_n)
        (trk_reg & ~used_reg) == '0)
        else $error("tracked mark on an unused slot");

    assert property (@(posedge clk) disable iff (!rst_n)
        hrd_vld_reg |-> $past(state_reg == ST_HIST))
        else $error("history sample read outside a history read");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |-> ($past(state_reg) == ST_SCAN))
        else $error("table update without a completed search");

endmodule

// ===== src/device_table_with_rssi_history_unit.sv =====
// Top level of the device table with per-entry signal-strength history.
// A command's address is compared against one slot per cycle through the address RAM, and
// the search ends at the first matching slot or at the last slot of the table.
// A history read then emits one sample per cycle from the history RAM, plus a done result.
// The back end takes one command at a time and pops it with its last result; a two-entry
// queue takes new commands meanwhile.
// Reset clears the used and tracked marks, ring positions and counts at once; results
// are single-cycle strobes that the receiver cannot stall.
module device_table_with_rssi_history_unit #(
    parameter int TABLE_ENTRIES = dtrh_pkg::TABLE_ENTRIES_DEF,
    parameter int HISTORY_DEPTH = dtrh_pkg::HISTORY_DEPTH_DEF,
    parameter int TRACK_LIMIT   = dtrh_pkg::TRACK_LIMIT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        opcode,
    input  logic [47:0]       device_address,
    input  logic signed [7:0] signal_strength,
    input  logic [31:0]       now_ms,
    output logic              result_valid,
    output logic [2:0]        kind,
    output logic [1:0]        error_code,
    output logic [47:0]       entry_address,
    output logic signed [7:0] entry_rssi,
    output logic              entry_tracked,
    output logic [31:0]       seen_time,
    output logic              last_of_run
);
    import dtrh_pkg::*;

    // Commands waiting for the back end; the head stays in the queue until its
    // last result transfer has been issued.
    cmd_t    q_head;
    logic    q_valid;
    logic    q_pop;
    result_t res;

    // The front end classifies each command: observations and track starts may
    // allocate a free slot, the other commands only look an address up.
    dtrh_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .opcode          (opcode),
        .device_address  (device_address),
        .signal_strength (signal_strength),
        .now_ms          (now_ms),
        .busy            (busy),
        .q_head          (q_head),
        .q_valid         (q_valid),
        .q_pop           (q_pop)
    );

    // The back end sweeps the slots, updates the table and sequences the results.
    dtrh_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .TRACK_LIMIT   (TRACK_LIMIT)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_head  (q_head),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .res     (res)
    );

    // Every result comes straight from the back end's output register.
    assign result_valid  = res.valid;
    assign kind          = res.kind;
    assign error_code    = res.err;
    assign entry_address = res.addr;
    assign entry_rssi    = res.rssi;
    assign entry_tracked = res.tracked;
    assign seen_time     = res.seen;
    assign last_of_run   = res.last;

endmodule
